/* src/qrgs_pkg.sv */
// qrgs_pkg: shared types, codes and fixed-point helpers of the qr solver
package qrgs_pkg;

    // fixed field and bus widths, and the divider and root step counts
    localparam int IDX_W      = 5;
    localparam int CNT_W      = 6;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 72;
    localparam int DIV_STEPS  = 57;
    localparam int SQRT_STEPS = 32;

    localparam logic signed [31:0] ONE_Q   = 32'sh0100_0000;
    localparam logic signed [31:0] Q_MAX   = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;

    // input item kinds
    localparam logic [1:0] FUNC_LOAD_A = 2'd0;
    localparam logic [1:0] FUNC_LOAD_B = 2'd1;
    localparam logic [1:0] FUNC_SOLVE  = 2'd2;

    // operation carried by one sweep along the chain
    typedef enum logic [2:0] {
        OP_DOT,
        OP_UPD,
        OP_NRM,
        OP_SCL,
        OP_QTB,
        OP_BSB
    } op_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_MUL,
        CS_ACC,
        CS_DIV
    } cell_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_COL,
        S_DOT,
        S_UPD,
        S_NRM,
        S_SQRT,
        S_SCL,
        S_QTB,
        S_BSB,
        S_BDIV,
        S_DMUL,
        S_DACC,
        S_EMIT
    } state_t;

    // sweep command, held steady for the whole sweep
    typedef struct packed {
        op_t                op;
        logic [IDX_W-1:0]   ci;
        logic [IDX_W-1:0]   cj;
        logic [CNT_W-1:0]   n;
        logic signed [31:0] s;
    } cmd_t;

    // direct writes into the cells
    typedef struct packed {
        logic               a_we;
        logic               b_we;
        logic               r_we;
        logic               x_we;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic signed [31:0] data;
    } wr_t;

    // packet handed from cell to cell
    typedef struct packed {
        logic        valid;
        logic [63:0] acc;
    } link_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
            r = Q_MAX;
        else if (v < -66'sd2147483648)
            r = Q_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    // round a raw product to q16.24, half up
    function automatic logic signed [39:0] rnd_q(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + 64'sd8388608;
        return t[63:24];
    endfunction

endpackage

/* src/qrgs_div.sv */
// qrgs_div: radix-2 restoring divider giving a rounded, saturated q8.24 quotient
module qrgs_div
    import qrgs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [31:0] quo
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [56:0] q_reg;
    logic [31:0] ad_reg;
    logic        neg_reg;

    logic [32:0] an_full;
    logic [32:0] ad_full;
    logic [56:0] num_full;
    logic [32:0] trial;
    logic        fits;

    // magnitudes and the scaled, half-rounded numerator
    always_comb
    begin
        an_full  = num[31] ? -{num[31], num} : {num[31], num};
        ad_full  = den[31] ? -{den[31], den} : {den[31], den};
        num_full = {1'b0, an_full[31:0], 24'd0} + 57'(ad_full[31:1]);
        trial    = {rem_reg, q_reg[56]};
        fits     = trial >= {1'b0, ad_reg};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= (ad_full[31:0] != 32'd0);
                done_reg <= (ad_full[31:0] == 32'd0);
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= (ad_full[31:0] == 32'd0) ? 57'd0 : num_full;
            ad_reg  <= ad_full[31:0];
            neg_reg <= num[31] ^ den[31];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? 32'(trial - {1'b0, ad_reg}) : trial[31:0];
            q_reg   <= {q_reg[55:0], fits};
        end
    end

    // sign and saturation
    always_comb
    begin
        if (|q_reg[56:31])
            quo = neg_reg ? Q_MIN : Q_MAX;
        else
            quo = neg_reg ? -q_reg[31:0] : q_reg[31:0];
    end

    assign done = done_reg;

endmodule

/* src/qrgs_sqrt.sv */
// qrgs_sqrt: bit-serial floor square root of a 64-bit sum, saturated to 31 bits
module qrgs_sqrt
    import qrgs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [63:0]        radicand,
    output logic               done,
    output logic signed [31:0] root
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] s_reg;
    logic [63:0] r_reg;
    logic [63:0] bit_reg;
    logic [63:0] trial;

    assign trial = r_reg + bit_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(SQRT_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one root bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s_reg   <= radicand;
            r_reg   <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (s_reg >= trial)
            begin
                s_reg <= s_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign root = (|r_reg[63:31]) ? Q_MAX : r_reg[31:0];
    assign done = done_reg;

endmodule

/* src/qrgs_cell.sv */
// qrgs_cell: one chain cell holding a row of the basis, a column of r, b and x
module qrgs_cell
    import qrgs_pkg::*;
#(
    parameter int MAX_SIZE = 8,
    parameter int CELL_IDX = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  cmd_t  cmd,
    input  wr_t   wr,
    input  link_t link_in,
    output link_t link_out
);

    localparam int IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

    cell_state_t state_reg, state_next;

    logic signed [31:0] row_mem  [MAX_SIZE];
    logic signed [31:0] rcol_mem [MAX_SIZE];
    logic signed [31:0] rhs_reg;
    logic signed [31:0] x_reg;
    logic signed [31:0] rd_a_reg;
    logic signed [31:0] rd_b_reg;
    logic signed [31:0] rd_r_reg;
    logic        [63:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic               out_valid_reg;
    logic        [63:0] out_acc_reg;

    logic               mine;
    logic               active;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [39:0] rnd;
    logic        [64:0] sq_sum;
    logic        [63:0] acc_new;
    logic               emit;
    logic        [63:0] emit_acc;
    logic               op_we;
    logic signed [31:0] op_wdata;
    logic               div_start;
    logic               div_done;
    logic signed [31:0] div_quo;

    assign mine   = (wr.row == IDX_W'(CELL_IDX));
    assign active = (CNT_W'(CELL_IDX) < cmd.n)
                    && ((cmd.op != OP_BSB) || (IDX_W'(CELL_IDX) > cmd.ci));

    // multiplier operand selection
    always_comb
    begin
        case (cmd.op)
            OP_DOT:
            begin
                mul_a = rd_a_reg;
                mul_b = rd_b_reg;
            end
            OP_UPD:
            begin
                mul_a = cmd.s;
                mul_b = rd_b_reg;
            end
            OP_NRM:
            begin
                mul_a = rd_a_reg;
                mul_b = rd_a_reg;
            end
            OP_QTB:
            begin
                mul_a = rd_a_reg;
                mul_b = rhs_reg;
            end
            OP_BSB:
            begin
                mul_a = rd_r_reg;
                mul_b = x_reg;
            end
            default:
            begin
                mul_a = rd_a_reg;
                mul_b = rd_b_reg;
            end
        endcase
    end

    // accumulate step
    always_comb
    begin
        rnd    = rnd_q(prod_reg);
        sq_sum = {1'b0, acc_reg} + {1'b0, prod_reg};
        case (cmd.op)
            OP_DOT, OP_QTB, OP_BSB: acc_new = acc_reg + {{24{rnd[39]}}, rnd};
            OP_NRM:                 acc_new = sq_sum[64] ? '1 : sq_sum[63:0];
            default:                acc_new = acc_reg;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE: if (link_in.valid && active) state_next = CS_MUL;
            CS_MUL:  state_next = (cmd.op == OP_SCL) ? CS_DIV : CS_ACC;
            CS_ACC:  state_next = CS_IDLE;
            CS_DIV:  if (div_done) state_next = CS_IDLE;
            default: state_next = CS_IDLE;
        endcase
    end

    // outputs of the cell sequencer
    always_comb
    begin
        emit      = 1'b0;
        emit_acc  = acc_reg;
        op_we     = 1'b0;
        op_wdata  = div_quo;
        div_start = 1'b0;
        unique case (state_reg)
            CS_IDLE:
            begin
                emit     = link_in.valid && !active;
                emit_acc = link_in.acc;
            end
            CS_MUL:
            begin
                div_start = (cmd.op == OP_SCL);
            end
            CS_ACC:
            begin
                emit     = 1'b1;
                emit_acc = acc_new;
                op_we    = (cmd.op == OP_UPD);
                op_wdata = sat32({{34{rd_a_reg[31]}}, rd_a_reg} - {{26{rnd[39]}}, rnd});
            end
            CS_DIV:
            begin
                emit  = div_done;
                op_we = div_done;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // sequencer and link registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= emit;
        end
    end

    // row and column stores with registered reads
    always_ff @(posedge clk)
    begin
        if (wr.a_we && mine)
            row_mem[wr.col[IW-1:0]] <= wr.data;
        else if (op_we)
            row_mem[cmd.ci[IW-1:0]] <= op_wdata;
        if (wr.r_we && mine)
            rcol_mem[wr.col[IW-1:0]] <= wr.data;
        rd_a_reg <= row_mem[cmd.ci[IW-1:0]];
        rd_b_reg <= row_mem[cmd.cj[IW-1:0]];
        rd_r_reg <= rcol_mem[cmd.ci[IW-1:0]];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (wr.b_we && mine)
            rhs_reg <= wr.data;
        if (wr.x_we && mine)
            x_reg <= wr.data;
        if (state_reg == CS_IDLE && link_in.valid)
            acc_reg <= link_in.acc;
        if (state_reg == CS_MUL)
            prod_reg <= mul_a * mul_b;
        if (emit)
            out_acc_reg <= emit_acc;
    end

    qrgs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (rd_a_reg),
        .den   (cmd.s),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign link_out.valid = out_valid_reg;
    assign link_out.acc   = out_acc_reg;

endmodule

/* src/qr_gram_schmidt_solver.sv */
// qr_gram_schmidt_solver: top level with solve sequencer, cell chain and result stage
//
// Solves A x = b for up to MAX_SIZE unknowns in signed q8.24 by modified
// Gram-Schmidt QR. Load items (tuser 0 for A, 1 for b) are taken while idle.
// A solve item runs a sequence of sweeps along a chain of MAX_SIZE cells, cell k
// holding row k of A (then Q), column k of R, b[k] and x[k]; a column scaling
// sweep is slow because each cell's 57-step divider runs in turn, and these
// sweeps dominate a full solve. Then n results stream out at one per cycle
// while m_tready is held, the last with tlast. No item is taken during a solve.
module qr_gram_schmidt_solver
    import qrgs_pkg::*;
#(
    parameter int MAX_SIZE = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [3:0]          cfg_data,    // size_in_use
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,     // row_index, col_index, element_value
    input  logic [1:0]          s_tuser,     // func
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,     // solution_index, solution_value, determinant
    output logic                m_tuser,     // singular
    output logic                m_tlast      // last_of_run
);

    localparam int IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

    state_t state_reg, state_next;

    logic               sent_reg;
    logic [CNT_W-1:0]   i_reg;
    logic [CNT_W-1:0]   j_reg;
    logic [CNT_W-1:0]   n_reg;
    logic               singular_reg;
    logic [3:0]         size_reg;
    logic signed [31:0] s_reg;
    logic signed [31:0] det_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] y_mem    [MAX_SIZE];
    logic signed [31:0] diag_mem [MAX_SIZE];
    logic signed [31:0] x_mem    [MAX_SIZE];
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic                m_tuser_reg;
    logic                m_tlast_reg;

    logic [2:0]         in_row;
    logic [2:0]         in_col;
    logic signed [31:0] in_value;
    logic               s_acc;
    logic               sweep;
    logic               sweep_done;
    logic               launch;
    logic               div_start;
    logic               div_done;
    logic signed [31:0] div_quo;
    logic signed [31:0] bsb_num;
    logic               sq_start;
    logic               sq_done;
    logic signed [31:0] sq_root;
    logic               out_free;
    logic               out_load;
    logic               i_last;
    logic [CNT_W-1:0]   n_clamped;
    logic signed [31:0] acc_sat;
    logic signed [39:0] det_rnd;
    cmd_t               cmd;
    wr_t                wr;
    link_t              link_w [MAX_SIZE+1];

    assign in_row   = s_tdata[2:0];
    assign in_col   = s_tdata[5:3];
    assign in_value = s_tdata[37:6];

    assign cfg_ready  = 1'b1;
    assign s_tready   = (state_reg == S_IDLE);
    assign s_acc      = s_tvalid && s_tready;
    assign sweep      = (state_reg == S_DOT) || (state_reg == S_UPD) || (state_reg == S_NRM)
                        || (state_reg == S_SCL) || (state_reg == S_QTB)
                        || (state_reg == S_BSB);
    assign sweep_done = link_w[MAX_SIZE].valid;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign i_last     = (i_reg == n_reg - CNT_W'(1));
    assign acc_sat    = sat32({{2{link_w[MAX_SIZE].acc[63]}}, link_w[MAX_SIZE].acc});
    assign det_rnd    = rnd_q(prod_reg);
    assign bsb_num    = sat32({{34{y_mem[i_reg[IW-1:0]][31]}}, y_mem[i_reg[IW-1:0]]}
                              - {{2{link_w[MAX_SIZE].acc[63]}}, link_w[MAX_SIZE].acc});

    // size register clamped to the supported range
    always_comb
    begin
        if (size_reg == 4'd0)
            n_clamped = CNT_W'(1);
        else if (32'(size_reg) > MAX_SIZE)
            n_clamped = CNT_W'(MAX_SIZE);
        else
            n_clamped = CNT_W'(size_reg);
    end

    // sweep command
    always_comb
    begin
        cmd.ci = i_reg[IDX_W-1:0];
        cmd.cj = j_reg[IDX_W-1:0];
        cmd.n  = n_reg;
        cmd.s  = s_reg;
        unique case (state_reg)
            S_UPD:   cmd.op = OP_UPD;
            S_NRM:   cmd.op = OP_NRM;
            S_SCL:   cmd.op = OP_SCL;
            S_QTB:   cmd.op = OP_QTB;
            S_BSB:   cmd.op = OP_BSB;
            default: cmd.op = OP_DOT;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_acc && s_tuser == FUNC_SOLVE) state_next = S_COL;
            S_COL:
            begin
                if (i_reg == n_reg)
                    state_next = S_QTB;
                else if (j_reg < i_reg)
                    state_next = S_DOT;
                else
                    state_next = S_NRM;
            end
            S_DOT:  if (sweep_done) state_next = S_UPD;
            S_UPD:  if (sweep_done) state_next = S_COL;
            S_NRM:  if (sweep_done) state_next = S_SQRT;
            S_SQRT: if (sq_done) state_next = (sq_root == 32'sd0) ? S_EMIT : S_SCL;
            S_SCL:  if (sweep_done) state_next = S_COL;
            S_QTB:  if (sweep_done && i_last) state_next = S_BSB;
            S_BSB:  if (sweep_done) state_next = S_BDIV;
            S_BDIV: if (div_done) state_next = (i_reg == '0) ? S_DMUL : S_BSB;
            S_DMUL: state_next = S_DACC;
            S_DACC: if (i_last) state_next = S_EMIT; else state_next = S_DMUL;
            S_EMIT: if (out_free && i_last) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // strobes and cell writes
    always_comb
    begin
        launch    = sweep && !sent_reg;
        div_start = (state_reg == S_BSB) && sweep_done;
        sq_start  = (state_reg == S_NRM) && sweep_done;
        out_load  = (state_reg == S_EMIT) && out_free;
        wr.a_we   = 1'b0;
        wr.b_we   = 1'b0;
        wr.r_we   = 1'b0;
        wr.x_we   = 1'b0;
        wr.row    = IDX_W'(in_row);
        wr.col    = IDX_W'(in_col);
        wr.data   = in_value;
        unique case (state_reg)
            S_IDLE:
            begin
                wr.a_we = s_acc && (s_tuser == FUNC_LOAD_A)
                          && (32'(in_row) < MAX_SIZE) && (32'(in_col) < MAX_SIZE);
                wr.b_we = s_acc && (s_tuser == FUNC_LOAD_B) && (32'(in_row) < MAX_SIZE);
            end
            S_DOT:
            begin
                wr.r_we = sweep_done;
                wr.row  = i_reg[IDX_W-1:0];
                wr.col  = j_reg[IDX_W-1:0];
                wr.data = acc_sat;
            end
            S_BDIV:
            begin
                wr.x_we = div_done;
                wr.row  = i_reg[IDX_W-1:0];
                wr.data = div_quo;
            end
            default:
            begin
                wr.a_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            sent_reg     <= 1'b0;
            i_reg        <= '0;
            j_reg        <= '0;
            n_reg        <= CNT_W'(1);
            singular_reg <= 1'b0;
            size_reg     <= 4'd8;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                size_reg <= cfg_data;
            if (launch)
                sent_reg <= 1'b1;
            else if (sweep_done)
                sent_reg <= 1'b0;
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_acc && s_tuser == FUNC_SOLVE)
                    begin
                        i_reg        <= '0;
                        j_reg        <= '0;
                        n_reg        <= n_clamped;
                        singular_reg <= 1'b0;
                    end
                end
                S_COL:
                begin
                    if (i_reg == n_reg)
                        i_reg <= '0;
                end
                S_UPD:
                begin
                    if (sweep_done)
                        j_reg <= j_reg + CNT_W'(1);
                end
                S_SQRT:
                begin
                    if (sq_done && sq_root == 32'sd0)
                    begin
                        singular_reg <= 1'b1;
                        i_reg        <= '0;
                    end
                end
                S_SCL:
                begin
                    if (sweep_done)
                    begin
                        i_reg <= i_reg + CNT_W'(1);
                        j_reg <= '0;
                    end
                end
                S_QTB:
                begin
                    if (sweep_done && !i_last)
                        i_reg <= i_reg + CNT_W'(1);
                end
                S_BDIV:
                begin
                    if (div_done && i_reg != '0)
                        i_reg <= i_reg - CNT_W'(1);
                end
                S_DACC:
                begin
                    if (i_last)
                        i_reg <= '0;
                    else
                        i_reg <= i_reg + CNT_W'(1);
                end
                S_EMIT:
                begin
                    if (out_free && !i_last)
                        i_reg <= i_reg + CNT_W'(1);
                end
                default:
                begin
                    i_reg <= i_reg;
                end
            endcase
        end
    end

    // solve payload and result stage
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DOT && sweep_done)
            s_reg <= acc_sat;
        if (state_reg == S_SQRT && sq_done)
        begin
            s_reg                    <= sq_root;
            diag_mem[i_reg[IW-1:0]] <= sq_root;
            if (sq_root == 32'sd0)
                det_reg <= 32'sd0;
        end
        if (state_reg == S_QTB && sweep_done)
            y_mem[i_reg[IW-1:0]] <= acc_sat;
        if (state_reg == S_BDIV && div_done)
        begin
            x_mem[i_reg[IW-1:0]] <= div_quo;
            if (i_reg == '0)
                det_reg <= ONE_Q;
        end
        if (state_reg == S_DMUL)
            prod_reg <= det_reg * diag_mem[i_reg[IW-1:0]];
        if (state_reg == S_DACC)
            det_reg <= sat32({{26{det_rnd[39]}}, det_rnd});
        if (out_load)
        begin
            m_tdata_reg <= {5'd0, det_reg,
                            singular_reg ? 32'sd0 : x_mem[i_reg[IW-1:0]],
                            i_reg[2:0]};
            m_tuser_reg <= singular_reg;
            m_tlast_reg <= i_last;
        end
    end

    // chain of cells
    assign link_w[0].valid = launch;
    assign link_w[0].acc   = '0;

    for (genvar k = 0; k < MAX_SIZE; k++)
    begin : g_cell
        qrgs_cell #(
            .MAX_SIZE (MAX_SIZE),
            .CELL_IDX (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .wr       (wr),
            .link_in  (link_w[k]),
            .link_out (link_w[k+1])
        );
    end

    qrgs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (bsb_num),
        .den   (diag_mem[i_reg[IW-1:0]]),
        .done  (div_done),
        .quo   (div_quo)
    );

    qrgs_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (link_w[MAX_SIZE].acc),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // a packet leaves the chain only during a sweep
    a_chain_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        link_w[MAX_SIZE].valid |-> sweep)
        else $error("chain packet outside a sweep");

    // the back-substitution divider finishes only while awaited
    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_BDIV))
        else $error("divider result while not awaited");

    // the root unit finishes only while awaited
    a_sqrt_owned: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> (state_reg == S_SQRT))
        else $error("root result while not awaited");

    // the final result of a run returns the block to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && i_last) |=> (state_reg == S_IDLE))
        else $error("block not idle after last result");

endmodule
